@@ design/rau_pkg.sv @@
// rau_pkg: shared types and constants for the rational arithmetic unit
// used by rau_ctrl, rau_dp, rau_div and rational_arithmetic_unit
`default_nettype none
package rau_pkg;
  localparam int MagW = 64;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } opcode_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture operands
    logic mul_start;  // start the three products
    logic combine;    // form signed numerator and denominator
    logic gcd_start;  // start gcd
    logic red_start;  // start the two reducing divisions
    logic finish;     // form the result
  } rau_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic mul_done;
    logic gcd_done;
    logic red_done;
  } rau_sts_t;
endpackage
`default_nettype wire

@@ design/rational_arithmetic_unit.sv @@
// rational_arithmetic_unit: top level, fraction add/sub/mul/div with gcd reduction
// depends on rau_pkg, rau_ctrl, rau_dp (which holds rau_div)
//
// channel | dir | tdata fields (low bit up)                         | tuser
// in_     | in  | left_num[31:0] left_den right_num right_den        | opcode[1:0]
// out_    | out | result_num[31:0] result_den[30:0] overflow          | none
//
// one transaction in flight: three products and control, then one division per euclid
// remainder step, then the two reducing divisions;
// the 64-bit restoring divider (one bit per cycle) sets the pace
// synchronous active-low reset returns the sequencer to idle
// in_tready is low from acceptance until the result transaction is taken
`default_nettype none
module rational_arithmetic_unit
  import rau_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [127:0] in_tdata,  // left_num, left_den, right_num, right_den
  input  wire logic [1:0]   in_tuser,  // opcode
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [63:0]       out_tdata  // result_num, result_den, overflow
);
  rau_cmd_t    cmd;
  rau_sts_t    sts;
  logic [31:0] rnum;
  logic [30:0] rden;
  logic        ovf;

  rau_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .out_valid(out_tvalid), .out_ready(out_tready), .zero_case(1'b0),
    .cmd(cmd), .sts(sts)
  );

  rau_dp #(.WIDTH(WIDTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .opcode(in_tuser),
    .left_num(in_tdata[31:0]), .left_den(in_tdata[63:32]),
    .right_num(in_tdata[95:64]), .right_den(in_tdata[127:96]),
    .result_num(rnum), .result_den(rden), .overflow(ovf)
  );

  assign out_tdata = {ovf, rden, rnum};
endmodule
`default_nettype wire

@@ design/rau_div.sv @@
// rau_div: restoring divider, one quotient bit per cycle, 64-bit operands
// depends on rau_pkg
`default_nettype none
module rau_div
  import rau_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [MagW-1:0] dividend,
  input  wire logic [MagW-1:0] divisor,
  output logic                 done,
  output logic [MagW-1:0]      quot,
  output logic [MagW-1:0]      rem
);
  logic [MagW-1:0] q_r, q_nxt, r_r, r_nxt, d_r, d_nxt;
  logic [6:0]      cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt, done_r, done_nxt;
  logic [MagW:0]   sh;

  always_comb begin
    q_nxt = q_r; r_nxt = r_r; d_nxt = d_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    sh = {r_r, q_r[MagW-1]};
    if (start) begin
      q_nxt = dividend; r_nxt = '0; d_nxt = divisor;
      cnt_nxt = 7'(MagW); busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt = {q_r[MagW-2:0], 1'b0};
      if (sh >= {1'b0, d_r}) begin
        r_nxt = MagW'(sh - {1'b0, d_r});
        q_nxt[0] = 1'b1;
      end else begin
        r_nxt = sh[MagW-1:0];
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt; r_r <= r_nxt; d_r <= d_nxt; cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = r_r;
endmodule
`default_nettype wire

@@ design/rau_dp.sv @@
// rau_dp: operand registers, 32x32 products, euclid gcd and reduction
// depends on rau_pkg and rau_div
`default_nettype none
module rau_dp
  import rau_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire rau_cmd_t    cmd,
  output rau_sts_t         sts,
  input  wire logic [1:0]  opcode,
  input  wire logic [31:0] left_num,
  input  wire logic [31:0] left_den,
  input  wire logic [31:0] right_num,
  input  wire logic [31:0] right_den,
  output logic [31:0]      result_num,
  output logic [30:0]      result_den,
  output logic             overflow
);
  localparam logic [MagW-1:0] Limit = MagW'((64'd1 << (WIDTH - 1)) - 64'd1);

  opcode_t          op_r;
  logic             s_ln_r, s_ld_r, s_rn_r, s_rd_r;
  logic [WIDTH-1:0] m_ln_r, m_ld_r, m_rn_r, m_rd_r;
  logic [MagW-1:0]  pa_r, pb_r, pc_r, n_r, d_r, a_r, b_r, g_r;
  logic             nn_r, nd_r, mul_done_r;
  logic             gbusy_r, gdone_r, gwait_r;
  logic [31:0]      rnum_r;
  logic [30:0]      rden_r;
  logic             ovf_r;

  function automatic logic [WIDTH:0] split(input logic [31:0] raw);
    logic [WIDTH-1:0] v;
    logic             s;
    v = raw[WIDTH-1:0];
    s = v[WIDTH-1];
    return {s, s ? WIDTH'(-v) : v};
  endfunction

  // one 32x32 product per cycle, three products for the set
  // phase 1: ln*rd (ln*rn for multiply), phase 2: ld*rn (ld*rd for multiply),
  // phase 3: ld*rd
  logic [WIDTH-1:0] ma, mb;
  logic [MagW-1:0]  prod;
  logic [1:0]       mph_r;
  always_comb begin
    case (mph_r)
      2'd1: begin
        ma = m_ln_r;
        mb = (op_r == OP_MUL) ? m_rn_r : m_rd_r;
      end
      2'd2: begin
        ma = m_ld_r;
        mb = (op_r == OP_MUL) ? m_rd_r : m_rn_r;
      end
      default: begin
        ma = m_ld_r;
        mb = m_rd_r;
      end
    endcase
  end
  assign prod = MagW'(ma) * MagW'(mb);

  // shared divider: gcd remainders, then two reductions
  logic            dv_start, dv_done;
  logic [MagW-1:0] dv_a, dv_b, dv_q, dv_r;
  logic [1:0]      red_r;
  logic            red_done_r;
  logic [MagW-1:0] qn_r;

  rau_div u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .dividend(dv_a),
    .divisor(dv_b), .done(dv_done), .quot(dv_q), .rem(dv_r)
  );

  always_comb begin
    dv_start = 1'b0; dv_a = a_r; dv_b = b_r;
    if (gbusy_r && !gwait_r && b_r != '0) dv_start = 1'b1;
    if (cmd.red_start) begin
      dv_start = 1'b1; dv_a = n_r; dv_b = g_r;
    end else if (red_r == 2'd1 && dv_done) begin
      dv_start = 1'b1; dv_a = d_r; dv_b = g_r;
    end
  end

  logic [MagW-1:0] sum_a, sum_b;
  logic            sg_a, sg_b;
  always_comb begin
    sum_a = pa_r; sum_b = pb_r;
    sg_a = s_ln_r ^ s_rd_r;
    sg_b = (s_rn_r ^ s_ld_r) ^ (op_r == OP_SUB);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= opcode_t'(opcode);
      {s_ln_r, m_ln_r} <= split(left_num);
      {s_ld_r, m_ld_r} <= split(left_den);
      {s_rn_r, m_rn_r} <= split(right_num);
      {s_rd_r, m_rd_r} <= split(right_den);
    end
    if (mph_r == 2'd1) pa_r <= prod;
    if (mph_r == 2'd2) pb_r <= prod;
    if (mph_r == 2'd3) pc_r <= prod;
    if (cmd.combine) begin
      if (op_r == OP_ADD || op_r == OP_SUB) begin
        if (sg_a == sg_b) begin
          nn_r <= sg_a; n_r <= sum_a + sum_b;
        end else if (sum_a >= sum_b) begin
          nn_r <= sg_a; n_r <= sum_a - sum_b;
        end else begin
          nn_r <= sg_b; n_r <= sum_b - sum_a;
        end
        nd_r <= s_ld_r ^ s_rd_r;
        d_r <= pc_r;
      end else if (op_r == OP_MUL) begin
        nn_r <= s_ln_r ^ s_rn_r; nd_r <= s_ld_r ^ s_rd_r; n_r <= pa_r;
        d_r <= pb_r;
      end else begin
        nn_r <= s_ln_r ^ s_rd_r; nd_r <= s_ld_r ^ s_rn_r; n_r <= pa_r;
        d_r <= pb_r;
      end
    end
    if (cmd.gcd_start) begin
      a_r <= n_r; b_r <= d_r;
    end else if (gbusy_r && gwait_r && dv_done) begin
      a_r <= b_r; b_r <= dv_r;
    end
    if (gbusy_r && b_r == '0 && !gwait_r) g_r <= a_r;
    if (red_r == 2'd1 && dv_done) qn_r <= dv_q;
    if (cmd.finish) begin
      if (d_r == '0) begin
        rnum_r <= '0; rden_r <= '0; ovf_r <= 1'b0;
      end else if (n_r == '0) begin
        rnum_r <= '0; rden_r <= 31'd1; ovf_r <= 1'b0;
      end else if (qn_r > Limit || dv_q > Limit) begin
        rnum_r <= '0; rden_r <= '0; ovf_r <= 1'b1;
      end else begin
        rnum_r <= (nn_r != nd_r) ? 32'(-qn_r) : qn_r[31:0];
        rden_r <= dv_q[30:0];
        ovf_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mph_r <= 2'd0; mul_done_r <= 1'b0; gbusy_r <= 1'b0; gdone_r <= 1'b0;
      gwait_r <= 1'b0; red_r <= 2'd0; red_done_r <= 1'b0;
    end else begin
      if (cmd.mul_start) mph_r <= 2'd1;
      else if (mph_r != 2'd0) mph_r <= mph_r + 2'd1;
      mul_done_r <= (mph_r == 2'd3);
      gdone_r <= 1'b0;
      red_done_r <= 1'b0;
      if (cmd.gcd_start) begin
        gbusy_r <= 1'b1; gwait_r <= 1'b0;
      end else if (gbusy_r) begin
        if (!gwait_r) begin
          if (b_r == '0) begin
            gbusy_r <= 1'b0; gdone_r <= 1'b1;
          end else begin
            gwait_r <= 1'b1;
          end
        end else if (dv_done) begin
          gwait_r <= 1'b0;
        end
      end
      if (cmd.red_start) red_r <= 2'd1;
      else if (red_r == 2'd1 && dv_done) red_r <= 2'd2;
      else if (red_r == 2'd2 && dv_done) begin
        red_r <= 2'd0; red_done_r <= 1'b1;
      end
    end
  end

  assign sts.mul_done = mul_done_r;
  assign sts.gcd_done = gdone_r;
  assign sts.red_done = red_done_r;
  assign result_num = rnum_r;
  assign result_den = rden_r;
  assign overflow   = ovf_r;
endmodule
`default_nettype wire

@@ design/rau_ctrl.sv @@
// rau_ctrl: sequencing state machine and output handshake
// depends on rau_pkg
`default_nettype none
module rau_ctrl
  import rau_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  input  wire logic zero_case,
  output rau_cmd_t  cmd,
  input  wire rau_sts_t sts
);
  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_COMB, S_GCD, S_RED, S_FIN, S_OUT
  } state_t;
  state_t state_r;
  logic   go_gcd;

  always_comb begin
    cmd = '0;
    cmd.load      = (state_r == S_IDLE) && in_valid;
    cmd.mul_start = cmd.load;
    cmd.combine   = (state_r == S_MUL) && sts.mul_done;
    go_gcd        = (state_r == S_COMB) && !zero_case;
    cmd.gcd_start = go_gcd;
    cmd.red_start = (state_r == S_GCD) && sts.gcd_done;
    cmd.finish    = (state_r == S_FIN);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: if (in_valid) state_r <= S_MUL;
        S_MUL:  if (sts.mul_done) state_r <= S_COMB;
        S_COMB: state_r <= zero_case ? S_FIN : S_GCD;
        S_GCD:  if (sts.gcd_done) state_r <= S_RED;
        S_RED:  if (sts.red_done) state_r <= S_FIN;
        S_FIN:  state_r <= S_OUT;
        S_OUT:  if (out_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready while result pending");
  a_fin_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid) else $error("finish without result");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
endmodule
`default_nettype wire

@@ tb/tb_rational_arithmetic_unit.sv @@
// testbench for rational_arithmetic_unit: fraction add/sub/mul/div with gcd reduction
// a local predictor computes each reduced fraction; a scoreboard class checks the results
// depends on rau_pkg and the rational_arithmetic_unit rtl
`timescale 1ns / 100ps
`default_nettype none
module tb_rational_arithmetic_unit
  import rau_pkg::*;
();

  localparam int WIDTH = 32;
  localparam int IDLE_LIMIT = 200000;  // worst gcd is ~90 euclid steps plus stalls

  typedef struct {
    logic [31:0] num;
    logic [30:0] den;
    logic        ovf;
  } fraction_t;

  // split a WIDTH-bit operand into sign and magnitude
  function automatic void split_operand(input logic [31:0] raw, output bit neg,
                                        output logic [63:0] mag);
    logic [63:0] v;
    v = 64'(raw[WIDTH-1:0]);
    neg = v[WIDTH-1];
    mag = neg ? ((~v + 64'd1) & ((64'd1 << WIDTH) - 64'd1)) : v;
  endfunction

  function automatic logic [63:0] gcd64(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  // exact reduced fraction for one operation
  function automatic fraction_t reduce_fraction(input opcode_t op, input logic [31:0] ln_raw,
      input logic [31:0] ld_raw, input logic [31:0] rn_raw, input logic [31:0] rd_raw);
    bit sln, sld, srn, srd, sn, sd, sa, sb;
    logic [63:0] ln, ld, rn, rd, n, d, a, b, g;
    logic [63:0] lim;
    fraction_t f;
    lim = (64'd1 << (WIDTH - 1)) - 64'd1;
    split_operand(ln_raw, sln, ln);
    split_operand(ld_raw, sld, ld);
    split_operand(rn_raw, srn, rn);
    split_operand(rd_raw, srd, rd);
    case (op)
      OP_ADD, OP_SUB: begin
        sa = sln != srd;
        a = ln * rd;
        sb = (srn != sld) ^ (op == OP_SUB);
        b = rn * ld;
        if (sa == sb) begin
          sn = sa; n = a + b;
        end else if (a >= b) begin
          sn = sa; n = a - b;
        end else begin
          sn = sb; n = b - a;
        end
        sd = sld != srd;
        d = ld * rd;
      end
      OP_MUL: begin
        sn = sln != srn; n = ln * rn;
        sd = sld != srd; d = ld * rd;
      end
      default: begin
        sn = sln != srd; n = ln * rd;
        sd = sld != srn; d = ld * rn;
      end
    endcase
    f.num = '0; f.den = '0; f.ovf = 1'b0;
    if (d == 0) return f;  // not-a-number
    if (n == 0) begin
      f.den = 31'd1;
      return f;
    end
    g = gcd64(n, d);
    n = n / g;
    d = d / g;
    if (n > lim || d > lim) begin
      f.ovf = 1'b1;
      return f;
    end
    f.num = (sn != sd) ? (~n[31:0] + 32'd1) : n[31:0];
    f.den = d[30:0];
    return f;
  endfunction

  class fraction_scoreboard;
    fraction_t pending[$];
    int errors;
    int checked;

    function void note_operands(opcode_t op, logic [31:0] ln, logic [31:0] ld,
                                logic [31:0] rn, logic [31:0] rd);
      pending.push_back(reduce_fraction(op, ln, ld, rn, rd));
    endfunction

    function void check_result(logic [63:0] data);
      fraction_t want;
      if (pending.size() == 0) begin
        $error("result transaction with nothing pending: %h", data);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (data[31:0] !== want.num) begin
        $error("result_num expected %0d actual %0d", $signed(want.num), $signed(data[31:0]));
        errors++;
      end
      if (data[62:32] !== want.den) begin
        $error("result_den expected %0d actual %0d", want.den, data[62:32]);
        errors++;
      end
      if (data[63] !== want.ovf) begin
        $error("overflow expected %0b actual %0b", want.ovf, data[63]);
        errors++;
      end
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;   // left_num, left_den, right_num, right_den
  logic [1:0]   in_tuser;   // opcode
  logic         out_tvalid;
  logic         out_tready;
  logic [63:0]  out_tdata;  // result_num, result_den, overflow

  fraction_scoreboard sb;
  int send_idle_pct;   // percent of cycles the sender holds off
  int recv_stall_pct;  // percent of cycles the receiver stalls
  int idle_cycles;
  int sent;

  rational_arithmetic_unit #(.WIDTH(WIDTH)) dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver: random stalls, every result transaction goes to the scoreboard
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one transaction, with random hold-off before it; tvalid stays up for a
  // back-to-back follower and is dropped by a hold-off or by drain
  task automatic send_fraction(input opcode_t op, input logic [31:0] ln, input logic [31:0] ld,
                               input logic [31:0] rn, input logic [31:0] rd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {rd, rn, ld, ln};
    do @(posedge clk); while (!in_tready);
    sb.note_operands(op, ln, ld, rn, rd);
    sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // operand mix: small values so gcds reduce, plus full-range and extreme values
  function automatic logic [31:0] pick_value();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'd0;
      3, 4: return 32'($signed($urandom_range(40)) - 20);
      5: return 32'($signed($urandom_range(2000)) - 1000) * 32'($urandom_range(12) + 1);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_phase(input int count);
    opcode_t op;
    logic [31:0] ld, rd;
    repeat (count) begin
      op = opcode_t'($urandom_range(3));
      ld = pick_value();
      rd = pick_value();
      // keep not-a-number operands rare
      if (ld == 0 && $urandom_range(3) != 0) ld = 32'd1;
      if (rd == 0 && $urandom_range(3) != 0) rd = 32'd7;
      send_fraction(op, pick_value(), ld, pick_value(), rd);
    end
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = OP_ADD;
    out_tready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    idle_cycles = 0;
    sent = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every opcode, extremes, not-a-number, zero, overflow, sign handling
    send_fraction(OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
    send_fraction(OP_SUB, 32'd1, 32'd2, 32'd1, 32'd2);              // zero gives 0/1
    send_fraction(OP_MUL, 32'd2, 32'd3, 32'd3, 32'd4);
    send_fraction(OP_DIV, 32'd2, 32'd3, 32'd4, 32'd9);
    send_fraction(OP_ADD, 32'd1, 32'd0, 32'd1, 32'd2);              // not-a-number left
    send_fraction(OP_MUL, 32'd5, 32'd7, 32'd3, 32'd0);              // not-a-number right
    send_fraction(OP_DIV, 32'd5, 32'd7, 32'd0, 32'd3);              // divide by zero
    send_fraction(OP_MUL, 32'd3, -32'sd4, 32'd1, 32'd1);            // negative denominator
    send_fraction(OP_DIV, -32'sd6, -32'sd4, 32'd1, 32'd1);
    send_fraction(OP_MUL, 32'h8000_0000, 32'd1, 32'd1, 32'd1);      // most negative overflows
    send_fraction(OP_DIV, 32'h8000_0000, 32'd2, 32'd1, 32'd1);
    send_fraction(OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'd5, 32'd7);
    send_fraction(OP_MUL, 32'h7fff_ffff, 32'd1, 32'h7fff_ffff, 32'd1);
    send_fraction(OP_ADD, 32'h7fff_ffff, 32'd1, 32'h7fff_ffff, 32'd1);
    send_fraction(OP_SUB, 32'h8000_0001, 32'd1, 32'h7fff_ffff, 32'd1);
    send_fraction(OP_ADD, 32'd1, 32'h7fff_ffff, 32'd1, 32'h7fff_fffe);
    send_fraction(OP_SUB, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_fraction(OP_DIV, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send_fraction(OP_ADD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_fraction(OP_DIV, 32'h5555_5555, 32'haaaa_aaaa, 32'hffff_0000, 32'h0000_ffff);
    drain();

    // sender pauses until every result has arrived, then random phases
    send_idle_pct = 24; recv_stall_pct = 77;
    random_phase(150);
    drain();
    send_idle_pct = 77; recv_stall_pct = 24;
    random_phase(150);
    send_idle_pct = 0; recv_stall_pct = 0;
    random_phase(150);

    drain();
    repeat (20) @(posedge clk);
    $display("run covered %0d fraction transactions over all four opcodes, %0d results checked",
             sent, sb.checked);
    $display("including not-a-number, zero, overflow and most-negative operands");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
`default_nettype wire
